// ===== hw/rtl/har_pkg.sv =====
// ----------------------------------------------------------------------------
// har_pkg: shared types and constants for the HID axis resolution block
// Unit codes, scale factors and widths used by the top level and the divider.
// ----------------------------------------------------------------------------
package har_pkg;

   // extents and resolution are positive s32 values, so 31 bits hold them
   localparam int EXT_W = 31;
   localparam int EXP_W = 6;
   localparam int MUL_W = 10;

   typedef logic [EXT_W-1:0]        ext_type;
   typedef logic signed [EXP_W-1:0] exp_type;
   typedef logic [MUL_W-1:0]        mul_type;

   // axis classes
   localparam logic [1:0] KIND_LENGTH = 2'd0;
   localparam logic [1:0] KIND_ANGLE  = 2'd1;

   // unit word decoding
   localparam logic [31:0] LEN_UNIT_MASK = 32'hffffff00;
   localparam logic [3:0]  SYS_CM        = 4'h1;
   localparam logic [3:0]  SYS_INCH      = 4'h3;
   localparam logic [31:0] UNIT_DEG      = 32'h14;
   localparam logic [31:0] UNIT_RAD      = 32'h12;

   // scale factors fed to the shared multiplier
   localparam mul_type MUL_INCH = 10'd254;
   localparam mul_type MUL_DEG  = 10'd573;
   localparam mul_type MUL_TEN  = 10'd10;

   // pending unit conversion ahead of the power-of-ten steps
   localparam logic [1:0] PRE_NONE = 2'd0;
   localparam logic [1:0] PRE_INCH = 2'd1;
   localparam logic [1:0] PRE_DEG  = 2'd2;

endpackage

// ===== hw/rtl/har_if.sv =====
// ----------------------------------------------------------------------------
// har_req_if / har_rsp_if: valid/ready channels of the HID axis resolution block
// One word per handshake; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface har_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         axis_kind;
   logic signed [31:0] logical_min;
   logic signed [31:0] logical_max;
   logic signed [31:0] physical_min;
   logic signed [31:0] physical_max;
   logic [31:0]        unit_word;
   logic signed [3:0]  exponent;

   modport source (output valid, axis_kind, logical_min, logical_max, physical_min,
                   physical_max, unit_word, exponent, input ready);
   modport sink   (input valid, axis_kind, logical_min, logical_max, physical_min,
                   physical_max, unit_word, exponent, output ready);
endinterface

interface har_rsp_if;
   logic        valid;
   logic        ready;
   logic [30:0] resolution;

   modport source (output valid, resolution, input ready);
   modport sink   (input valid, resolution, output ready);
endinterface

// ===== hw/rtl/har_divider.sv =====
// ----------------------------------------------------------------------------
// har_divider: restoring radix-2 divider, one quotient bit per cycle
// 32-bit dividend over a 31-bit divisor, 32 steps; done pulses after the last one.
// ----------------------------------------------------------------------------
module har_divider (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [31:0]      numerator,
   input  har_pkg::ext_type divisor,
   output logic             done,
   output har_pkg::ext_type quotient
);

   har_pkg::ext_type rem_ff, rem_in;
   har_pkg::ext_type div_ff, div_in;
   logic [31:0]      quo_ff, quo_in;
   logic [4:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [31:0] trial;
   logic [31:0] diff;
   logic        ge;

   always_comb begin
      trial = {rem_ff, quo_ff[31]};
      diff  = trial - {1'b0, div_ff};
      ge    = (trial >= {1'b0, div_ff});

      rem_in  = rem_ff;
      div_in  = div_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (start) begin
         rem_in  = '0;
         div_in  = divisor;
         quo_in  = numerator;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[30:0] : trial[30:0];
         quo_in = {quo_ff[30:0], ge};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // quotient never exceeds the s32 maximum, so its top bit is always clear
   assign done     = done_ff;
   assign quotient = quo_ff[30:0];

endmodule

// ===== hw/rtl/hid_axis_resolution.sv =====
// ----------------------------------------------------------------------------
// hid_axis_resolution: resolution of one absolute HID axis
// Turns a report field's extents, unit and exponent into units per mm or rad.
// ----------------------------------------------------------------------------
// One request word describes a HID report field; one response word returns its
// resolution, (logical extent) / (physical extent * 10^exponent) rounded half
// up, after converting cm and inches to mm or degrees to radians. Invalid
// extents, other axis classes, unsupported units and any product above the
// s32 range give 0. The block works on one word at a time and is not ready
// while busy: a word is decoded as it is taken, then goes through one
// multiply per step on a single shared 31x10 constant multiplier (unit
// conversion plus one step per power of ten, at most 19), a hand-off step
// that starts the bit-serial divider, the divider itself and the load of the
// output register; a word rejected at decode goes straight to that load. A
// finished word waits in the output register while the next request is taken.
module hid_axis_resolution (
   input  logic      clock,
   input  logic      reset,
   har_req_if.sink   req_if,
   har_rsp_if.source rsp_if
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCALE  = 2'd1;
   localparam logic [1:0] ST_DIV    = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]       state_ff, state_in;
   har_pkg::ext_type lext_ff, lext_in;
   har_pkg::ext_type pext_ff, pext_in;
   har_pkg::exp_type ex_ff, ex_in;
   logic [1:0]       pre_ff, pre_in;
   logic             zero_ff, zero_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [30:0]      rsp_res_ff, rsp_res_in;

   logic div_start;
   logic div_done;
   har_pkg::ext_type div_quo;
   logic [31:0]      div_num;

   // request decode
   logic signed [32:0] lext_full;
   logic signed [32:0] pext_full;
   logic               ext_ok;
   har_pkg::exp_type   exp_s;
   har_pkg::exp_type   nib_s;
   logic               dec_bad;
   logic [1:0]         dec_pre;
   har_pkg::exp_type   dec_ex;

   // shared multiplier
   har_pkg::ext_type mul_a;
   har_pkg::mul_type mul_k;
   logic [40:0]      mul_p;
   logic             mul_ovf;

   logic accept;

   assign accept = req_if.valid && req_if.ready;

   always_comb begin
      lext_full = {req_if.logical_max[31], req_if.logical_max}
                - {req_if.logical_min[31], req_if.logical_min};
      pext_full = {req_if.physical_max[31], req_if.physical_max}
                - {req_if.physical_min[31], req_if.physical_min};
      // 0 < extent <= 2^31-1
      ext_ok = (lext_full[32:31] == 2'b00) && (|lext_full[30:0])
            && (pext_full[32:31] == 2'b00) && (|pext_full[30:0]);

      exp_s = {{2{req_if.exponent[3]}}, req_if.exponent};
      nib_s = {{2{req_if.unit_word[7]}}, req_if.unit_word[7:4]};

      dec_bad = !ext_ok;
      dec_pre = har_pkg::PRE_NONE;
      dec_ex  = exp_s;

      case (req_if.axis_kind)
         har_pkg::KIND_LENGTH: begin
            if (|(req_if.unit_word & har_pkg::LEN_UNIT_MASK)) begin
               dec_bad = 1'b1;
            end
            case (req_if.unit_word[3:0])
               har_pkg::SYS_CM: begin
                  dec_ex = exp_s + nib_s;
               end
               har_pkg::SYS_INCH: begin
                  dec_ex  = exp_s + nib_s - 6'sd2;
                  dec_pre = har_pkg::PRE_INCH;
               end
               default: begin
                  dec_bad = 1'b1;
               end
            endcase
         end
         har_pkg::KIND_ANGLE: begin
            if (req_if.unit_word == har_pkg::UNIT_DEG) begin
               dec_ex  = exp_s + 6'sd1;
               dec_pre = har_pkg::PRE_DEG;
            end else if (req_if.unit_word != har_pkg::UNIT_RAD) begin
               dec_bad = 1'b1;
            end
         end
         default: begin
            dec_bad = 1'b1;
         end
      endcase
   end

   // pick operand and factor for this scale step
   always_comb begin
      if (pre_ff == har_pkg::PRE_INCH) begin
         mul_a = pext_ff;
         mul_k = har_pkg::MUL_INCH;
      end else if (pre_ff == har_pkg::PRE_DEG) begin
         mul_a = lext_ff;
         mul_k = har_pkg::MUL_DEG;
      end else if (ex_ff < 0) begin
         mul_a = lext_ff;
         mul_k = har_pkg::MUL_TEN;
      end else begin
         mul_a = pext_ff;
         mul_k = har_pkg::MUL_TEN;
      end
      mul_p   = {10'd0, mul_a} * {31'd0, mul_k};
      mul_ovf = |mul_p[40:31];
   end

   // rounding: (L + P/2) / P, sum fits in 32 bits
   assign div_num = {1'b0, lext_ff} + {2'b00, pext_ff[30:1]};

   always_comb begin
      state_in     = state_ff;
      lext_in      = lext_ff;
      pext_in      = pext_ff;
      ex_in        = ex_ff;
      pre_in       = pre_ff;
      zero_in      = zero_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_res_in   = rsp_res_ff;
      div_start    = 1'b0;

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               lext_in  = lext_full[30:0];
               pext_in  = pext_full[30:0];
               ex_in    = dec_ex;
               pre_in   = dec_pre;
               zero_in  = dec_bad;
               state_in = dec_bad ? ST_FINISH : ST_SCALE;
            end
         end
         ST_SCALE: begin
            if (pre_ff == har_pkg::PRE_NONE && ex_ff == 0) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end else if (mul_ovf) begin
               zero_in  = 1'b1;
               state_in = ST_FINISH;
            end else begin
               // inch scales physical, degree scales logical
               if (pre_ff == har_pkg::PRE_INCH) begin
                  pext_in = mul_p[30:0];
               end else if (pre_ff == har_pkg::PRE_DEG) begin
                  lext_in = mul_p[30:0];
               end else if (ex_ff < 0) begin
                  lext_in = mul_p[30:0];
                  ex_in   = ex_ff + 6'sd1;
               end else begin
                  pext_in = mul_p[30:0];
                  ex_in   = ex_ff - 6'sd1;
               end
               pre_in = har_pkg::PRE_NONE;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_res_in   = zero_ff ? 31'd0 : div_quo;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      lext_ff    <= lext_in;
      pext_ff    <= pext_in;
      ex_ff      <= ex_in;
      pre_ff     <= pre_in;
      zero_ff    <= zero_in;
      rsp_res_ff <= rsp_res_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   har_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .numerator (div_num),
      .divisor   (pext_ff),
      .done      (div_done),
      .quotient  (div_quo)
   );

   assign req_if.ready      = (state_ff == ST_IDLE);
   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.resolution = rsp_res_ff;

endmodule

// ===== bench/tb_hid_axis_resolution.sv =====
// ----------------------------------------------------------------------------
// tb_hid_axis_resolution: self-checking bench for the HID axis resolution block
// Directed table of field descriptions, then random ones, scored word by word
// against a table value or an in-bench resolution predictor, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_hid_axis_resolution;

   localparam longint S32_MAX      = 64'sd2147483647;
   localparam int     RANDOM_WORDS = 1600;
   localparam int     CALM_TAIL    = 200;   // last random words go without idling
   localparam int     MAX_REPORTS  = 10;

   // short names for the package codes used throughout the table
   localparam logic [1:0]  KIND_LENGTH = har_pkg::KIND_LENGTH;
   localparam logic [1:0]  KIND_ANGLE  = har_pkg::KIND_ANGLE;
   localparam logic [3:0]  SYS_CM      = har_pkg::SYS_CM;
   localparam logic [3:0]  SYS_INCH    = har_pkg::SYS_INCH;
   localparam logic [31:0] UNIT_DEG    = har_pkg::UNIT_DEG;
   localparam logic [31:0] UNIT_RAD    = har_pkg::UNIT_RAD;

   // axis class with no package name: anything that is neither length nor angle
   localparam logic [1:0]  KIND_OTHER     = 2'd2;
   // length units: length exponent nibble, then system nibble
   localparam logic [31:0] UNIT_CM        = {24'd0, 4'h1, SYS_CM};
   localparam logic [31:0] UNIT_INCH      = {24'd0, 4'h1, SYS_INCH};
   localparam logic [31:0] UNIT_CM_NEG8   = {24'd0, 4'h8, SYS_CM};
   localparam logic [31:0] UNIT_CM_POS7   = {24'd0, 4'h7, SYS_CM};
   localparam logic [31:0] UNIT_BAD_SYS   = {24'd0, 4'h1, 4'h2};
   localparam logic [31:0] UNIT_HIGH_BITS = UNIT_CM | 32'h100;

   typedef struct {
      logic [1:0]         axis_kind;
      logic signed [31:0] logical_min;
      logic signed [31:0] logical_max;
      logic signed [31:0] physical_min;
      logic signed [31:0] physical_max;
      logic [31:0]        unit_word;
      logic signed [3:0]  exponent;
   } field_word_type;

   // typed = 1: want holds the resolution read straight off the spec
   typedef struct {
      field_word_type word;
      bit             typed;
      logic [30:0]    want;
   } field_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   har_req_if req_if ();
   har_rsp_if rsp_if ();

   hid_axis_resolution u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always #4 clock = ~clock;

   logic [30:0] expected_res_q[$];
   int          fail_count  = 0;
   int          stall_left  = 0;
   bit          idle_enable = 1'b1;

   // ------------------------------------------------------------------------
   // Directed words: extremes, every unit path, every reason for a zero.
   // ------------------------------------------------------------------------
   field_row_type field_table [23] = '{
      // cm length axis, needs the exponent nibble and the cm step
      '{'{KIND_LENGTH, 0, 1000, 0, 10, UNIT_CM, 4'sd0}, 1'b0, 31'd0},
      // inch length axis, physical side scaled by 254
      '{'{KIND_LENGTH, 0, 2540, 0, 10, UNIT_INCH, 4'sd0}, 1'b0, 31'd0},
      // degrees: logical side scaled by 573, one extra power of ten
      '{'{KIND_ANGLE, 0, 360, 0, 360, UNIT_DEG, 4'sd0}, 1'b0, 31'd0},
      // radians, extents straddling zero
      '{'{KIND_ANGLE, -32768, 32767, -1, 1, UNIT_RAD, 4'sd0}, 1'b0, 31'd0},
      // other axis class is never resolved
      '{'{KIND_OTHER, 0, 100, 0, 10, UNIT_RAD, 4'sd0}, 1'b1, 31'd0},
      // empty logical extent
      '{'{KIND_ANGLE, 5, 5, 0, 10, UNIT_RAD, 4'sd0}, 1'b1, 31'd0},
      // reversed physical extent
      '{'{KIND_ANGLE, 0, 100, 10, 0, UNIT_RAD, 4'sd0}, 1'b1, 31'd0},
      // logical extent wider than s32
      '{'{KIND_ANGLE, 32'sh80000000, 32'sh7fffffff, 0, 1, UNIT_RAD, 4'sd0}, 1'b1, 31'd0},
      // physical extent wider than s32
      '{'{KIND_ANGLE, 0, 1, 32'sh80000000, 32'sh7fffffff, UNIT_RAD, 4'sd0}, 1'b1, 31'd0},
      // length unit with bits above the first two nibbles
      '{'{KIND_LENGTH, 0, 100, 0, 10, UNIT_HIGH_BITS, 4'sd0}, 1'b1, 31'd0},
      // length unit in an unsupported system
      '{'{KIND_LENGTH, 0, 100, 0, 10, UNIT_BAD_SYS, 4'sd0}, 1'b1, 31'd0},
      // angle axis with a length unit
      '{'{KIND_ANGLE, 0, 100, 0, 10, UNIT_INCH, 4'sd0}, 1'b1, 31'd0},
      // inch scaling pushes physical past s32
      '{'{KIND_LENGTH, 0, 100, 0, 8454662, UNIT_INCH, 4'sd0}, 1'b1, 31'd0},
      // degree scaling pushes logical past s32
      '{'{KIND_ANGLE, 0, 3747790, 0, 1, UNIT_DEG, 4'sd0}, 1'b1, 31'd0},
      // most negative exponents: 10^16 on the logical side overflows
      '{'{KIND_LENGTH, 0, 1, 0, 1, UNIT_CM_NEG8, -4'sd8}, 1'b1, 31'd0},
      // largest exponent against the largest logical extent
      '{'{KIND_ANGLE, 0, 32'sh7fffffff, -5, -4, UNIT_RAD, 4'sd7}, 1'b0, 31'd0},
      // smallest exponent, radians: 10^8
      '{'{KIND_ANGLE, 0, 1, 0, 1, UNIT_RAD, -4'sd8}, 1'b0, 31'd0},
      // exact half rounds up
      '{'{KIND_ANGLE, 0, 3, 0, 2, UNIT_RAD, 4'sd0}, 1'b0, 31'd0},
      '{'{KIND_ANGLE, 0, 1, 0, 2, UNIT_RAD, 4'sd0}, 1'b0, 31'd0},
      // largest resolution the output can carry
      '{'{KIND_ANGLE, 32'sh80000000, -1, 0, 1, UNIT_RAD, 4'sd0}, 1'b1, 31'h7fffffff},
      // below one half rounds down to zero
      '{'{KIND_ANGLE, 0, 1, 0, 3, UNIT_RAD, 4'sd0}, 1'b0, 31'd0},
      // largest length exponent nibble
      '{'{KIND_LENGTH, 0, 5000, 0, 7, UNIT_CM_POS7, -4'sd8}, 1'b0, 31'd0},
      // power-of-ten steps push physical past s32
      '{'{KIND_ANGLE, 0, 100, 0, 1000000000, UNIT_RAD, 4'sd3}, 1'b1, 31'd0}
   };

   // ------------------------------------------------------------------------
   // Resolution predictor. Extents held in 64 bits so every product is exact.
   // ------------------------------------------------------------------------
   function automatic logic [30:0] predict_resolution(field_word_type w);
      longint lext;
      longint pext;
      longint ex;
      lext = longint'(w.logical_max) - longint'(w.logical_min);
      pext = longint'(w.physical_max) - longint'(w.physical_min);
      ex   = longint'(w.exponent);
      if (lext <= 0 || pext <= 0 || lext > S32_MAX || pext > S32_MAX)
         return '0;
      case (w.axis_kind)
         KIND_LENGTH: begin
            if ((w.unit_word & har_pkg::LEN_UNIT_MASK) != '0)
               return '0;
            ex = ex + longint'($signed(w.unit_word[7:4])) - 1;
            if (w.unit_word[3:0] == SYS_CM) begin
               ex = ex + 1;
            end else if (w.unit_word[3:0] == SYS_INCH) begin
               pext = pext * longint'(har_pkg::MUL_INCH);
               if (pext > S32_MAX)
                  return '0;
               ex = ex - 1;
            end else begin
               return '0;
            end
         end
         KIND_ANGLE: begin
            if (w.unit_word == UNIT_DEG) begin
               lext = lext * longint'(har_pkg::MUL_DEG);
               if (lext > S32_MAX)
                  return '0;
               ex = ex + 1;
            end else if (w.unit_word != UNIT_RAD) begin
               return '0;
            end
         end
         default: return '0;
      endcase
      // a negative exponent scales the logical side, a positive one the physical
      while (ex < 0) begin
         lext = lext * longint'(har_pkg::MUL_TEN);
         if (lext > S32_MAX)
            return '0;
         ex = ex + 1;
      end
      while (ex > 0) begin
         pext = pext * longint'(har_pkg::MUL_TEN);
         if (pext > S32_MAX)
            return '0;
         ex = ex - 1;
      end
      return 31'((lext + pext / 2) / pext);
   endfunction

   // span in 1 .. 2^bits-1, so small and huge extents both turn up
   function automatic longint rand_span(int bits);
      return longint'($urandom_range(1, 32'((64'd1 << bits) - 1)));
   endfunction

   // random placement of a min/max pair that keeps both ends in s32
   function automatic void place_extent(input longint span,
                                        output logic signed [31:0] lo,
                                        output logic signed [31:0] hi);
      lo = $urandom;
      if (longint'(lo) + span > S32_MAX)
         lo = 32'(S32_MAX - span);
      hi = 32'(longint'(lo) + span);
   endfunction

   // Mostly well-formed field descriptions with random content; the rest is
   // bad units, other axes and fully random noise.
   function automatic field_word_type random_field();
      field_word_type w;
      int             pick;
      pick = $urandom_range(0, 99);
      place_extent(rand_span($urandom_range(1, 31)), w.logical_min, w.logical_max);
      place_extent(rand_span($urandom_range(1, 14)), w.physical_min, w.physical_max);
      if ($urandom_range(0, 3) == 0)
         w.exponent = 4'($urandom);
      else
         w.exponent = 4'($urandom_range(0, 4) - 3);
      if (pick < 45) begin
         w.axis_kind = KIND_LENGTH;
         w.unit_word = $urandom_range(0, 1) ? UNIT_CM : UNIT_INCH;
         if ($urandom_range(0, 3) == 0)
            w.unit_word[7:4] = 4'($urandom);
         if ($urandom_range(0, 9) == 0)
            w.unit_word[3:0] = 4'($urandom);
         if ($urandom_range(0, 15) == 0)
            w.unit_word[31:8] = 24'($urandom);
      end else if (pick < 85) begin
         w.axis_kind = KIND_ANGLE;
         w.unit_word = $urandom_range(0, 1) ? UNIT_DEG : UNIT_RAD;
         if ($urandom_range(0, 9) == 0)
            w.unit_word = $urandom;
      end else if (pick < 92) begin
         w.axis_kind = KIND_OTHER;
         w.unit_word = $urandom;
      end else begin
         // noise: extents may be empty, reversed or wider than s32
         w.axis_kind    = 2'($urandom_range(0, 2));
         w.logical_min  = $urandom;
         w.logical_max  = $urandom;
         w.physical_min = $urandom;
         w.physical_max = $urandom;
         w.unit_word    = $urandom;
      end
      return w;
   endfunction

   // Offer one word at the falling edge, hold it until taken, then queue what
   // the block must answer. Valid stays high into the next word unless a gap
   // is drawn, so it is never dropped and raised in one step.
   task automatic send_field(input field_word_type w, input bit typed,
                             input logic [30:0] want);
      int gap;
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
         @(negedge clock);
         req_if.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_if.valid        <= 1'b1;
      req_if.axis_kind    <= w.axis_kind;
      req_if.logical_min  <= w.logical_min;
      req_if.logical_max  <= w.logical_max;
      req_if.physical_min <= w.physical_min;
      req_if.physical_max <= w.physical_max;
      req_if.unit_word    <= w.unit_word;
      req_if.exponent     <= w.exponent;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      expected_res_q.push_back(typed ? want : predict_resolution(w));
   endtask

   task automatic report_mismatch(input string what, input logic [30:0] want,
                                  input logic [30:0] got);
      fail_count++;
      if (fail_count <= MAX_REPORTS)
         $display("%0t: %s: expected resolution %0d, got %0d", $realtime, what,
                  want, got);
   endtask

   // ------------------------------------------------------------------------
   // Response side: random stall bursts, none in the tail.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left    <= stall_left - 1;
         rsp_if.ready  <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 7) == 0) begin
         stall_left    <= $urandom_range(0, 5);
         rsp_if.ready  <= 1'b0;
      end else begin
         rsp_if.ready  <= 1'b1;
      end
   end

   // scoreboard: every accepted response word against the oldest expectation
   always @(posedge clock) begin : score
      logic [30:0] want_res;
      if (reset === 1'b0 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (expected_res_q.size() == 0) begin
            report_mismatch("response with nothing pending", '0, rsp_if.resolution);
         end else begin
            want_res = expected_res_q.pop_front();
            if (rsp_if.resolution !== want_res)
               report_mismatch("resolution mismatch", want_res, rsp_if.resolution);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Main sequence: reset, directed table, random words, drain.
   // ------------------------------------------------------------------------
   initial begin
      req_if.valid        = 1'b0;
      req_if.axis_kind    = '0;
      req_if.logical_min  = '0;
      req_if.logical_max  = '0;
      req_if.physical_min = '0;
      req_if.physical_max = '0;
      req_if.unit_word    = '0;
      req_if.exponent     = '0;
      rsp_if.ready        = 1'b0;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (field_table[i])
         send_field(field_table[i].word, field_table[i].typed, field_table[i].want);

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n == RANDOM_WORDS - CALM_TAIL)
            idle_enable = 1'b0;
         send_field(random_field(), 1'b0, '0);
      end

      @(negedge clock);
      req_if.valid <= 1'b0;

      // drain, then watch a little longer for stray words
      while (expected_res_q.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);

      if (fail_count == 0)
         $display("** hid_axis_resolution: PASSED **");
      else
         $display("** hid_axis_resolution: FAILED **");
      $finish;
   end

   // hang guard: ends the run as failed if the main sequence has not finished
   initial begin
      #8000000;
      $display("** hid_axis_resolution: FAILED **");
      $finish;
   end

endmodule
